// File: src/tksi_pkg.sv
// shared types, constants and codes for the top-k sorted insert block
`timescale 1ns / 1ps

package tksi_pkg;

    localparam int MAX_K     = 16;
    localparam int MAX_WORDS = 8;

    // fixed field widths
    localparam int RATING_W = 32;
    localparam int WORD_W   = 32;
    localparam int ACT_W    = 2;
    localparam int STAT_W   = 2;
    localparam int RANK_W   = 4;
    localparam int SLOT_W   = 4;
    localparam int WIDX_W   = 3;
    localparam int CFG_W    = 5;

    // derived widths and the fixed compare width
    localparam int CNT_W   = $clog2(MAX_K + 1);
    localparam int WCNT_W  = $clog2(MAX_WORDS + 1);
    localparam int ADDR_W  = $clog2(MAX_K * MAX_WORDS);
    localparam int CMP_W   = 8;

    localparam logic [CFG_W-1:0] TOP_K_RESET = CFG_W'(16);

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_WORD   = 2'd1,
        ACT_READ   = 2'd2
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        STS_OK      = 2'd0,
        STS_REJECT  = 2'd1,
        STS_IGNORED = 2'd2,
        STS_RANGE   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_INSERT,
        ST_READ
    } t_state;

    // per-cell update control
    typedef struct packed {
        logic load_new;
        logic shift;
    } t_cell_ctrl;

endpackage

// File: src/tksi_cell.sv
// one rank cell: holds a rating and slot, compares, takes new or neighbor entry
`timescale 1ns / 1ps

module tksi_cell (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tksi_pkg::t_cell_ctrl                i_ctrl,
    input  logic signed [tksi_pkg::RATING_W-1:0] i_cmp_rating,
    input  logic signed [tksi_pkg::RATING_W-1:0] i_new_rating,
    input  logic        [tksi_pkg::SLOT_W-1:0]   i_new_slot,
    input  logic signed [tksi_pkg::RATING_W-1:0] i_prev_rating,
    input  logic        [tksi_pkg::SLOT_W-1:0]   i_prev_slot,
    output logic signed [tksi_pkg::RATING_W-1:0] o_rating,
    output logic        [tksi_pkg::SLOT_W-1:0]   o_slot,
    output logic                                o_gt
);
    import tksi_pkg::*;

    logic signed [RATING_W-1:0] r_rating;
    logic        [SLOT_W-1:0]   r_slot;
    logic signed [RATING_W-1:0] n_rating;
    logic        [SLOT_W-1:0]   n_slot;

    always_comb begin
        n_rating = r_rating;
        n_slot   = r_slot;
        if (i_ctrl.load_new) begin
            n_rating = i_new_rating;
            n_slot   = i_new_slot;
        end else if (i_ctrl.shift) begin
            n_rating = i_prev_rating;
            n_slot   = i_prev_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rating <= '0;
            r_slot   <= '0;
        end else begin
            r_rating <= n_rating;
            r_slot   <= n_slot;
        end
    end

    assign o_rating = r_rating;
    assign o_slot   = r_slot;
    assign o_gt     = i_cmp_rating > r_rating;

endmodule

// File: src/tksi_payload.sv
// payload word store, one write and one registered read port
`timescale 1ns / 1ps

module tksi_payload (
    input  logic                              i_clk,
    input  logic                              i_wr_en,
    input  logic [tksi_pkg::ADDR_W-1:0]       i_wr_addr,
    input  logic signed [tksi_pkg::WORD_W-1:0] i_wr_data,
    input  logic                              i_rd_en,
    input  logic [tksi_pkg::ADDR_W-1:0]       i_rd_addr,
    output logic signed [tksi_pkg::WORD_W-1:0] o_rd_data
);
    import tksi_pkg::*;

    logic signed [WORD_W-1:0] r_mem [MAX_K*MAX_WORDS];
    logic signed [WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/top_k_sorted_insert.sv
// top-k sorted insert: ranked list of best entries with payload store
//
//  channel   signals                                        beat taken when
//  command   i_start, i_action..i_word_index, o_busy        i_start && !o_busy
//  result    o_done, o_status..o_word_out                   o_done (one cycle)
//  config    i_cfg_valid, i_cfg_data, o_cfg_ready           i_cfg_valid && o_cfg_ready
//
// an insert: capture, parallel compare in every cell, shift of the cell row;
// a payload word: capture, write; a read: capture, payload memory read (capture
// alone when the rank is out of range). the result strobe comes in the cycle
// after, when busy is already low. reset is synchronous, active low, and clears
// the cells; the receiver cannot stall, each result shows for exactly one cycle.
`timescale 1ns / 1ps

module top_k_sorted_insert (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic [tksi_pkg::ACT_W-1:0]          i_action,
    input  logic signed [tksi_pkg::RATING_W-1:0] i_rating,
    input  logic signed [tksi_pkg::WORD_W-1:0]   i_payload_word,
    input  logic [tksi_pkg::RANK_W-1:0]         i_rank,
    input  logic [tksi_pkg::WIDX_W-1:0]         i_word_index,
    output logic                                o_done,
    output logic [tksi_pkg::STAT_W-1:0]         o_status,
    output logic [tksi_pkg::RANK_W-1:0]         o_placed_rank,
    output logic [tksi_pkg::SLOT_W-1:0]         o_slot,
    output logic signed [tksi_pkg::RATING_W-1:0] o_rating_out,
    output logic signed [tksi_pkg::WORD_W-1:0]   o_word_out,
    input  logic                                i_cfg_valid,
    input  logic [tksi_pkg::CFG_W-1:0]          i_cfg_data,
    output logic                                o_cfg_ready
);
    import tksi_pkg::*;

    t_state r_state, n_state;

    // captured command
    logic [ACT_W-1:0]           r_act;
    logic signed [RATING_W-1:0] r_rating_in;
    logic signed [WORD_W-1:0]   r_word_in;
    logic [RANK_W-1:0]          r_rank_in;
    logic [WIDX_W-1:0]          r_widx_in;

    // list control
    logic [CFG_W-1:0]  r_top_k;
    logic [CNT_W-1:0]  r_filled, n_filled;
    logic [SLOT_W-1:0] r_open_slot, n_open_slot;
    logic [WCNT_W-1:0] r_word_cnt, n_word_cnt;
    logic              r_open, n_open;
    logic [MAX_K-1:0]  r_gt, n_gt;
    logic [MAX_K-1:0]  r_used, n_used;

    logic [SLOT_W-1:0]          r_rd_slot, n_rd_slot;
    logic signed [RATING_W-1:0] r_rd_rating, n_rd_rating;

    // result register
    logic                       r_done, n_done;
    logic [STAT_W-1:0]          r_status, n_status;
    logic [RANK_W-1:0]          r_placed, n_placed;
    logic [SLOT_W-1:0]          r_slot, n_slot;
    logic signed [RATING_W-1:0] r_rating_o, n_rating_o;
    logic signed [WORD_W-1:0]   r_word_o, n_word_o;

    // cell row
    t_cell_ctrl                 cell_ctrl  [MAX_K];
    logic signed [RATING_W-1:0] c_rating   [MAX_K];
    logic        [SLOT_W-1:0]   c_slot     [MAX_K];
    logic [MAX_K-1:0]           c_gt;

    // memory port
    logic                     mem_wr_en, mem_rd_en;
    logic [ADDR_W-1:0]        mem_wr_addr, mem_rd_addr;
    logic signed [WORD_W-1:0] mem_rd_data;

    logic [CNT_W-1:0]  live_k, live_n;
    logic              full;
    logic [MAX_K-1:0]  sel;
    logic [RANK_W-1:0] pos;
    logic [SLOT_W-1:0] free_slot, new_slot;
    logic [RANK_W-1:0] last_idx;
    logic              accept_ins;
    logic              rank_ok;
    logic              word_ok;

    logic cmd_beat, cfg_beat;

    assign o_busy      = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign cmd_beat    = i_start && !o_busy;
    assign cfg_beat    = i_cfg_valid && o_cfg_ready;

    // register value 0 acts as 1, above the maximum acts as the maximum
    always_comb begin
        if (r_top_k == '0) begin
            live_k = CNT_W'(1);
        end else if (CMP_W'(r_top_k) > CMP_W'(MAX_K)) begin
            live_k = CNT_W'(MAX_K);
        end else begin
            live_k = CNT_W'(r_top_k);
        end
        live_n   = (r_filled < live_k) ? r_filled : live_k;
        full     = (live_n == live_k);
        last_idx = RANK_W'(live_n - CNT_W'(1));
    end

    // insert position: first live rank that is beaten, else the tail if room
    always_comb begin
        for (int i = 0; i < MAX_K; i++) begin
            if (CNT_W'(i) < live_n) begin
                sel[i] = r_gt[i];
            end else begin
                sel[i] = (CNT_W'(i) == live_n) && !full;
            end
        end
        accept_ins = |sel;
        pos = '0;
        for (int i = MAX_K - 1; i >= 0; i--) begin
            if (sel[i]) begin
                pos = RANK_W'(i);
            end
        end
        free_slot = SLOT_W'(MAX_K - 1);
        for (int s = MAX_K - 1; s >= 0; s--) begin
            if (!r_used[s]) begin
                free_slot = SLOT_W'(s);
            end
        end
        new_slot = full ? c_slot[last_idx] : free_slot;
    end

    always_comb begin
        for (int i = 0; i < MAX_K; i++) begin
            cell_ctrl[i].load_new = 1'b0;
            cell_ctrl[i].shift    = 1'b0;
            if (r_state == ST_INSERT) begin
                if (i == 0) begin
                    cell_ctrl[i].load_new = sel[i];
                end else begin
                    cell_ctrl[i].load_new = sel[i] && !sel[i-1];
                    cell_ctrl[i].shift    = sel[i] && sel[i-1];
                end
            end
        end
    end

    generate
        for (genvar g = 0; g < MAX_K; g++) begin : g_cell
            logic signed [RATING_W-1:0] prev_rating;
            logic        [SLOT_W-1:0]   prev_slot;
            if (g == 0) begin : g_head
                assign prev_rating = '0;
                assign prev_slot   = '0;
            end else begin : g_link
                assign prev_rating = c_rating[g-1];
                assign prev_slot   = c_slot[g-1];
            end
            tksi_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctrl        (cell_ctrl[g]),
                .i_cmp_rating  (r_rating_in),
                .i_new_rating  (r_rating_in),
                .i_new_slot    (new_slot),
                .i_prev_rating (prev_rating),
                .i_prev_slot   (prev_slot),
                .o_rating      (c_rating[g]),
                .o_slot        (c_slot[g]),
                .o_gt          (c_gt[g])
            );
        end
    endgenerate

    assign rank_ok = CNT_W'(r_rank_in) < live_n;
    assign word_ok = r_open && (r_word_cnt < WCNT_W'(MAX_WORDS));

    tksi_payload u_payload (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (r_word_in),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (cmd_beat) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (r_act)
                    ACT_INSERT: n_state = ST_INSERT;
                    ACT_READ:   n_state = rank_ok ? ST_READ : ST_IDLE;
                    default:    n_state = ST_IDLE;
                endcase
            end
            ST_INSERT: n_state = ST_IDLE;
            ST_READ:   n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_filled    = r_filled;
        n_open_slot = r_open_slot;
        n_word_cnt  = r_word_cnt;
        n_open      = r_open;
        n_gt        = r_gt;
        n_used      = r_used;
        n_rd_slot   = r_rd_slot;
        n_rd_rating = r_rd_rating;
        n_done      = 1'b0;
        n_status    = r_status;
        n_placed    = r_placed;
        n_slot      = r_slot;
        n_rating_o  = r_rating_o;
        n_word_o    = r_word_o;
        mem_wr_en   = 1'b0;
        mem_rd_en   = 1'b0;
        mem_wr_addr = ADDR_W'(r_open_slot) * ADDR_W'(MAX_WORDS) + ADDR_W'(r_word_cnt);
        mem_rd_addr = ADDR_W'(c_slot[r_rank_in]) * ADDR_W'(MAX_WORDS) + ADDR_W'(r_widx_in);
        case (r_state)
            ST_EXEC: begin
                case (r_act)
                    ACT_INSERT: begin
                        n_gt   = c_gt;
                        n_used = '0;
                        for (int i = 0; i < MAX_K; i++) begin
                            if (CNT_W'(i) < live_n) begin
                                n_used[c_slot[i]] = 1'b1;
                            end
                        end
                    end
                    ACT_WORD: begin
                        n_done     = 1'b1;
                        n_placed   = '0;
                        n_rating_o = '0;
                        n_word_o   = '0;
                        if (word_ok) begin
                            mem_wr_en  = 1'b1;
                            n_word_cnt = r_word_cnt + WCNT_W'(1);
                            n_status   = STS_OK;
                            n_slot     = r_open_slot;
                        end else begin
                            n_status = STS_IGNORED;
                            n_slot   = '0;
                        end
                    end
                    ACT_READ: begin
                        if (rank_ok) begin
                            mem_rd_en   = 1'b1;
                            n_rd_slot   = c_slot[r_rank_in];
                            n_rd_rating = c_rating[r_rank_in];
                        end else begin
                            n_done     = 1'b1;
                            n_status   = STS_RANGE;
                            n_placed   = '0;
                            n_slot     = '0;
                            n_rating_o = '0;
                            n_word_o   = '0;
                        end
                    end
                    default: begin
                        n_done     = 1'b1;
                        n_status   = STS_IGNORED;
                        n_placed   = '0;
                        n_slot     = '0;
                        n_rating_o = '0;
                        n_word_o   = '0;
                    end
                endcase
            end
            ST_INSERT: begin
                n_done     = 1'b1;
                n_rating_o = '0;
                n_word_o   = '0;
                // a lowered top_k truncates the fill on every insert
                n_filled   = live_n;
                if (accept_ins) begin
                    if (!full) begin
                        n_filled = live_n + CNT_W'(1);
                    end
                    n_open_slot = new_slot;
                    n_word_cnt  = '0;
                    n_open      = 1'b1;
                    n_status    = STS_OK;
                    n_placed    = pos;
                    n_slot      = new_slot;
                end else begin
                    n_open   = 1'b0;
                    n_status = STS_REJECT;
                    n_placed = '0;
                    n_slot   = '0;
                end
            end
            ST_READ: begin
                n_done     = 1'b1;
                n_status   = STS_OK;
                n_placed   = '0;
                n_slot     = r_rd_slot;
                n_rating_o = r_rd_rating;
                n_word_o   = mem_rd_data;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_top_k     <= TOP_K_RESET;
            r_filled    <= '0;
            r_open_slot <= '0;
            r_word_cnt  <= '0;
            r_open      <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_filled    <= n_filled;
            r_open_slot <= n_open_slot;
            r_word_cnt  <= n_word_cnt;
            r_open      <= n_open;
            r_done      <= n_done;
            if (cfg_beat) begin
                r_top_k <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_beat) begin
            r_act       <= i_action;
            r_rating_in <= i_rating;
            r_word_in   <= i_payload_word;
            r_rank_in   <= i_rank;
            r_widx_in   <= i_word_index;
        end
        r_gt        <= n_gt;
        r_used      <= n_used;
        r_rd_slot   <= n_rd_slot;
        r_rd_rating <= n_rd_rating;
        r_status    <= n_status;
        r_placed    <= n_placed;
        r_slot      <= n_slot;
        r_rating_o  <= n_rating_o;
        r_word_o    <= n_word_o;
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_placed_rank = r_placed;
    assign o_slot        = r_slot;
    assign o_rating_out  = r_rating_o;
    assign o_word_out    = r_word_o;

endmodule

// File: sim/top_k_sorted_insert_tb.sv
// self-checking testbench for the top-k sorted insert block
`timescale 1ns / 1ps

module top_k_sorted_insert_tb;
    import tksi_pkg::*;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 300000;
    localparam int SHOWN_LIMIT = 10;

    typedef struct {
        logic [ACT_W-1:0]           action;
        logic signed [RATING_W-1:0] rating;
        logic signed [WORD_W-1:0]   word;
        logic [RANK_W-1:0]          rank;
        logic [WIDX_W-1:0]          word_index;
    } t_cmd;

    typedef struct {
        t_status                    status;
        logic [RANK_W-1:0]          placed_rank;
        logic [SLOT_W-1:0]          slot;
        logic signed [RATING_W-1:0] rating_out;
        logic signed [WORD_W-1:0]   word_out;
    } t_outcome;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_start = 1'b0;
    logic [ACT_W-1:0]            i_action = '0;
    logic signed [RATING_W-1:0]  i_rating = '0;
    logic signed [WORD_W-1:0]    i_payload_word = '0;
    logic [RANK_W-1:0]           i_rank = '0;
    logic [WIDX_W-1:0]           i_word_index = '0;
    logic                        i_cfg_valid = 1'b0;
    logic [CFG_W-1:0]            i_cfg_data = '0;
    logic                        o_busy;
    logic                        o_done;
    logic [STAT_W-1:0]           o_status;
    logic [RANK_W-1:0]           o_placed_rank;
    logic [SLOT_W-1:0]           o_slot;
    logic signed [RATING_W-1:0]  o_rating_out;
    logic signed [WORD_W-1:0]    o_word_out;
    logic                        o_cfg_ready;

    top_k_sorted_insert i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_action       (i_action),
        .i_rating       (i_rating),
        .i_payload_word (i_payload_word),
        .i_rank         (i_rank),
        .i_word_index   (i_word_index),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_placed_rank  (o_placed_rank),
        .o_slot         (o_slot),
        .o_rating_out   (o_rating_out),
        .o_word_out     (o_word_out),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .o_cfg_ready    (o_cfg_ready)
    );

    always #5 i_clk = ~i_clk;

    // shadow of the ranked list
    logic [CFG_W-1:0]           top_k_reg = TOP_K_RESET;
    logic signed [RATING_W-1:0] list_rating [MAX_K];
    logic [SLOT_W-1:0]          list_slot [MAX_K];
    int unsigned                list_len = 0;
    logic signed [WORD_W-1:0]   payload_mem [MAX_K*MAX_WORDS];
    int unsigned                open_slot = 0;
    int unsigned                words_taken = 0;
    logic                       insert_open = 1'b0;

    t_cmd     cmd_queue [$];
    t_outcome outcome_q [$];
    t_cmd     drv_cmd;
    logic     cmd_taken = 1'b0;
    int       idle_pct = 0;
    int       bad_count = 0;
    int       cycle_count = 0;

    initial begin
        for (int j = 0; j < MAX_K; j++) begin
            list_rating[j] = '0;
            list_slot[j] = '0;
        end
    end

    function automatic t_outcome predict_outcome(t_cmd c);
        t_outcome    o;
        int unsigned k;
        int unsigned n;
        int unsigned pos;
        int unsigned slot;
        int unsigned i;
        logic [MAX_K-1:0] held;
        o.status = STS_OK;
        o.placed_rank = '0;
        o.slot = '0;
        o.rating_out = '0;
        o.word_out = '0;
        k = (top_k_reg == 0) ? 1 : (top_k_reg > MAX_K) ? MAX_K : top_k_reg;
        n = (list_len < k) ? list_len : k;
        case (c.action)
            ACT_INSERT: begin
                list_len = n;
                pos = n;
                // downward scan leaves the first strictly lower entry
                for (i = n; i > 0; i--)
                    if (c.rating > list_rating[i-1]) pos = i - 1;
                if (pos >= k) begin
                    insert_open = 1'b0;
                    o.status = STS_REJECT;
                end else begin
                    if (n == k) begin
                        // full: the last entry drops out and lends its slot
                        slot = list_slot[n-1];
                        i = n - 1;
                    end else begin
                        held = '0;
                        for (i = 0; i < n; i++) held[list_slot[i]] = 1'b1;
                        slot = 0;
                        while (slot < MAX_K - 1 && held[slot]) slot++;
                        i = n;
                        list_len = n + 1;
                    end
                    while (i > pos) begin
                        list_rating[i] = list_rating[i-1];
                        list_slot[i] = list_slot[i-1];
                        i--;
                    end
                    list_rating[pos] = c.rating;
                    list_slot[pos] = SLOT_W'(slot);
                    open_slot = slot;
                    words_taken = 0;
                    insert_open = 1'b1;
                    o.placed_rank = RANK_W'(pos);
                    o.slot = SLOT_W'(slot);
                end
            end
            ACT_WORD: begin
                if (!insert_open || words_taken >= MAX_WORDS) begin
                    o.status = STS_IGNORED;
                end else begin
                    payload_mem[open_slot*MAX_WORDS + words_taken] = c.word;
                    words_taken++;
                    o.slot = SLOT_W'(open_slot);
                end
            end
            ACT_READ: begin
                if (c.rank >= n) begin
                    o.status = STS_RANGE;
                end else begin
                    o.slot = list_slot[c.rank];
                    o.rating_out = list_rating[c.rank];
                    o.word_out = payload_mem[list_slot[c.rank]*MAX_WORDS + c.word_index];
                end
            end
            default: o.status = STS_IGNORED;
        endcase
        return o;
    endfunction

    // driver: a new beat only once the previous one went through
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_start || cmd_taken)) begin
            if (cmd_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
                drv_cmd = cmd_queue.pop_front();
                i_start <= 1'b1;
                i_action <= drv_cmd.action;
                i_rating <= drv_cmd.rating;
                i_payload_word <= drv_cmd.word;
                i_rank <= drv_cmd.rank;
                i_word_index <= drv_cmd.word_index;
            end else begin
                i_start <= 1'b0;
                i_action <= ACT_W'($urandom());
                i_rating <= $urandom();
                i_payload_word <= $urandom();
                i_rank <= RANK_W'($urandom());
                i_word_index <= WIDX_W'($urandom());
            end
        end
    end

    // monitor: check results first, then record the beat taken at this edge
    always @(posedge i_clk) begin
        t_outcome exp;
        t_cmd     c;
        if (i_rst_n && o_done === 1'b1) begin
            if (outcome_q.size() == 0) begin
                if (bad_count < SHOWN_LIMIT)
                    $display("unexpected result: st=%0d pr=%0d sl=%0d rt=%0d w=%0d",
                             o_status, o_placed_rank, o_slot, o_rating_out, o_word_out);
                bad_count++;
            end else begin
                exp = outcome_q.pop_front();
                if (o_status !== exp.status || o_placed_rank !== exp.placed_rank ||
                    o_slot !== exp.slot || o_rating_out !== exp.rating_out ||
                    o_word_out !== exp.word_out) begin
                    if (bad_count < SHOWN_LIMIT)
                        $display("mismatch: exp %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d",
                                 exp.status, exp.placed_rank, exp.slot, exp.rating_out,
                                 exp.word_out, o_status, o_placed_rank, o_slot,
                                 o_rating_out, o_word_out);
                    bad_count++;
                end
            end
        end
        if (i_rst_n && i_start && o_busy === 1'b0) begin
            c.action = i_action;
            c.rating = i_rating;
            c.word = i_payload_word;
            c.rank = i_rank;
            c.word_index = i_word_index;
            outcome_q.push_back(predict_outcome(c));
        end
        cmd_taken <= i_rst_n && i_start && o_busy === 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic push_cmd(input logic [ACT_W-1:0] act, input logic [RATING_W-1:0] rat,
                            input logic [WORD_W-1:0] wd, input logic [RANK_W-1:0] rk,
                            input logic [WIDX_W-1:0] wi);
        t_cmd c;
        c.action = act;
        c.rating = rat;
        c.word = wd;
        c.rank = rk;
        c.word_index = wi;
        cmd_queue.push_back(c);
    endtask

    task automatic push_insert(input logic [RATING_W-1:0] rat);
        push_cmd(ACT_INSERT, rat, $urandom(), RANK_W'($urandom()), WIDX_W'($urandom()));
    endtask

    task automatic push_word(input logic [WORD_W-1:0] wd);
        push_cmd(ACT_WORD, $urandom(), wd, RANK_W'($urandom()), WIDX_W'($urandom()));
    endtask

    task automatic push_read(input logic [RANK_W-1:0] rk, input logic [WIDX_W-1:0] wi);
        push_cmd(ACT_READ, $urandom(), $urandom(), rk, wi);
    endtask

    task automatic push_unused();
        push_cmd(ACT_UNUSED, $urandom(), $urandom(), RANK_W'($urandom()),
                 WIDX_W'($urandom()));
    endtask

    // extremes, a narrow band that makes ties, or anything
    function automatic logic [RATING_W-1:0] pick_rating();
        int sel;
        sel = $urandom_range(9);
        case (sel)
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3, 4, 5, 6: return $signed($urandom_range(16)) - 8;
            default: return $urandom();
        endcase
    endfunction

    task automatic write_top_k(input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        top_k_reg = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // hold the sender until every expected result is back
    task automatic drain();
        while (cmd_queue.size() != 0 || i_start || outcome_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic gen_random(input int count);
        int made;
        int sel;
        int nw;
        made = 0;
        while (made < count) begin
            sel = $urandom_range(99);
            if (sel < 50) begin
                push_insert(pick_rating());
                nw = ($urandom_range(3) == 0) ? $urandom_range(10) : MAX_WORDS;
                repeat (nw) push_word($urandom());
                made += 1 + nw;
            end else if (sel < 85) begin
                push_read(RANK_W'($urandom_range(1) ? $urandom_range(15) :
                                  $urandom_range(3)),
                          WIDX_W'($urandom_range(7)));
                made++;
            end else if (sel < 93) begin
                push_word($urandom());
                made++;
            end else if (sel < 97) begin
                push_insert(pick_rating());
                made++;
            end else begin
                push_unused();
                made++;
            end
        end
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] k, input int idle, input int count);
        write_top_k(k);
        idle_pct = idle;
        gen_random(count);
        drain();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty list: nothing in range, no open insert
        idle_pct = 0;
        push_read(0, 0);
        push_read(15, 7);
        push_word($urandom());
        push_unused();
        drain();

        // fill every slot with a whole payload so no read meets an unwritten word
        idle_pct = 31;
        for (int s = 0; s < MAX_K; s++) begin
            push_insert(s == 0 ? 32'h0 : s == 1 ? 32'h7fff_ffff :
                        s == 2 ? 32'h8000_0000 : pick_rating());
            repeat (MAX_WORDS) push_word($urandom());
            if (s % 4 == 3) begin
                push_word($urandom());
                push_read(RANK_W'($urandom_range(15)), WIDX_W'($urandom_range(7)));
            end
        end
        drain();

        // full list: reject, eviction, ties, word after a reject
        idle_pct = 0;
        push_read(0, 0);
        push_read(15, 7);
        push_insert(32'h8000_0000);
        push_word(32'hffff_ffff);
        push_insert(32'h7fff_ffff);
        repeat (MAX_WORDS) push_word($urandom());
        push_word(32'h8000_0000);
        push_insert(32'h0);
        push_insert(32'h0);
        push_read(0, 3);
        push_read(15, 0);
        push_unused();
        drain();

        run_phase(5'd1, 0, 100);
        run_phase(5'd0, 67, 100);
        run_phase(5'd31, 31, 100);
        run_phase(5'd5, 0, 100);
        run_phase(5'd17, 67, 100);
        run_phase(5'd3, 31, 100);
        run_phase(5'd16, 0, 100);

        repeat (10) @(negedge i_clk);
        if (bad_count == 0 && outcome_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
